// ===== design/hel_pkg.sv =====
// Package for the histogram equalization table block.
// Holds field widths, codes and the structs shared by the divider and the top level.
// No dependencies.
package hel_pkg;

    localparam int LEVEL_W     = 8;
    localparam int CHANNEL_W   = 2;
    localparam int COUNT_W     = 32;
    localparam int NUM_CH_W    = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int QUOT_W      = 8;
    localparam int NUM_W       = 42;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CHANNELS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS = 1'b1;

    localparam logic [NUM_CH_W-1:0] NUM_CH_RESET   = 3'd1;
    localparam logic [NUM_CH_W-1:0] NUM_CH_TWO     = 3'd2;
    localparam logic [NUM_CH_W-1:0] NUM_CH_FOUR    = 3'd4;
    localparam logic [COUNT_W-1:0]  TOTAL_RESET    = 32'd1;
    localparam logic [QUOT_W-1:0]   QUOT_MAX       = 8'hFF;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] sum;
        logic [COUNT_W-1:0] total;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/hel_if.sv =====
// Valid/ready channel interfaces for the histogram equalization table block.
// Depends on hel_pkg for the payload widths.
interface hel_item_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [hel_pkg::CHANNEL_W-1:0] channel;
    logic [hel_pkg::LEVEL_W-1:0]   level;
    logic [hel_pkg::COUNT_W-1:0]   bin_count;

    modport source (output valid, opcode, channel, level, bin_count, input ready);
    modport sink   (input valid, opcode, channel, level, bin_count, output ready);
endinterface

interface hel_result_if;
    logic                        valid;
    logic                        ready;
    logic [hel_pkg::LEVEL_W-1:0] mapped_level;

    modport source (output valid, mapped_level, input ready);
    modport sink   (input valid, mapped_level, output ready);
endinterface

// ===== design/hel_table.sv =====
// Equalization table memory: one write port, one read port with registered data.
// No package dependency.
module hel_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/hel_divider.sv =====
// Iterative scaler: quotient of (sum * 510 + total) / (2 * total), saturated at 255.
// One quotient bit per cycle after a saturation check. Depends on hel_pkg.
module hel_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  hel_pkg::div_req_t req,
    output hel_pkg::div_rsp_t rsp
);

    localparam int SW = $clog2(hel_pkg::QUOT_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(hel_pkg::QUOT_W - 1);

    typedef enum logic [1:0] {IDLE, PREP, CHECK, ITER} state_t;

    state_t                          state_reg;
    logic [hel_pkg::COUNT_W-1:0]     sum_reg;
    logic [hel_pkg::COUNT_W-1:0]     total_reg;
    logic [hel_pkg::NUM_W-1:0]       num_reg;
    logic [hel_pkg::NUM_W-1:0]       dsh_reg;
    logic                            zero_reg;
    logic [SW-1:0]                   step_reg;
    logic [hel_pkg::QUOT_W-1:0]      quot_reg;
    logic                            done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (req.start)
                    begin
                        sum_reg   <= req.sum;
                        total_reg <= req.total;
                        state_reg <= PREP;
                    end
                end
                PREP:
                begin
                    num_reg   <= hel_pkg::NUM_W'({sum_reg, 9'b0})
                               - hel_pkg::NUM_W'({sum_reg, 1'b0})
                               + hel_pkg::NUM_W'(total_reg);
                    dsh_reg   <= hel_pkg::NUM_W'({total_reg, 8'b0});
                    zero_reg  <= (total_reg == '0);
                    state_reg <= CHECK;
                end
                CHECK:
                begin
                    if (zero_reg || num_reg >= (dsh_reg << 1))
                    begin
                        quot_reg  <= hel_pkg::QUOT_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= IDLE;
                    end
                    else
                    begin
                        quot_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ITER;
                    end
                end
                ITER:
                begin
                    if (num_reg >= dsh_reg)
                    begin
                        num_reg  <= num_reg - dsh_reg;
                        quot_reg <= {quot_reg[hel_pkg::QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quot_reg <= {quot_reg[hel_pkg::QUOT_W-2:0], 1'b0};
                    end
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ===== design/histogram_equalize_lut.sv =====
// Per-channel histogram equalization table. A map item is taken every cycle unless a load
// is busy or the output is stalled. Its result is registered in stage one, with the
// synchronous table read, then in the output register. A load item keeps the block busy
// until the bit-per-cycle divider is done (sooner if it saturates at 255); no item is taken
// until its table write is done. Depends on hel_pkg, hel_if, hel_table and hel_divider.
module histogram_equalize_lut #(
    parameter int LEVELS       = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    hel_item_if.sink                          item,
    hel_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [hel_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hel_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_CHANNELS * LEVELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {SEL_TABLE, SEL_PASS, SEL_ZERO} sel_t;

    logic [hel_pkg::NUM_CH_W-1:0] num_channels_reg;
    logic [hel_pkg::COUNT_W-1:0]  total_pixels_reg;
    logic [hel_pkg::COUNT_W-1:0]  running_sum_reg;
    logic                         busy_reg;
    logic                         wr_valid_reg;
    logic [AW-1:0]                wr_addr_reg;
    logic                         s1_valid_reg;
    sel_t                         s1_sel_reg;
    logic [hel_pkg::LEVEL_W-1:0]  s1_level_reg;
    logic                         out_valid_reg;
    logic [hel_pkg::LEVEL_W-1:0]  out_level_reg;

    logic                         advance;
    logic                         accept;
    logic                         load_accept;
    logic                         map_accept;
    logic [hel_pkg::COUNT_W-1:0]  sum_base;
    logic [hel_pkg::COUNT_W:0]    sum_wide;
    logic [hel_pkg::COUNT_W-1:0]  sum_next;
    logic                         ch_in_range;
    logic                         lv_in_range;
    logic                         is_alpha;
    logic [AW-1:0]                load_addr;
    logic [AW-1:0]                map_addr;
    logic [31:0]                  map_level;
    sel_t                         sel_next;
    logic [hel_pkg::LEVEL_W-1:0]  rd_data;
    logic                         tbl_we;
    hel_pkg::div_req_t            div_req;
    hel_pkg::div_rsp_t            div_rsp;

    assign advance     = !out_valid_reg || result.ready;
    assign item.ready  = !busy_reg && advance;
    assign accept      = item.valid && item.ready;
    assign load_accept = accept && (item.opcode == hel_pkg::OP_LOAD);
    assign map_accept  = accept && (item.opcode == hel_pkg::OP_MAP);

    assign sum_base = (item.level == '0) ? '0 : running_sum_reg;
    assign sum_wide = {1'b0, sum_base} + {1'b0, item.bin_count};
    assign sum_next = sum_wide[hel_pkg::COUNT_W] ? '1 : sum_wide[hel_pkg::COUNT_W-1:0];

    assign ch_in_range = 32'(item.channel) < 32'(MAX_CHANNELS);
    assign lv_in_range = 32'(item.level) < 32'(LEVELS);
    assign is_alpha    = ((num_channels_reg == hel_pkg::NUM_CH_TWO)
                          || (num_channels_reg == hel_pkg::NUM_CH_FOUR))
                         && ({1'b0, item.channel} == num_channels_reg - 1'b1);

    assign map_level = lv_in_range ? 32'(item.level) : 32'(LEVELS - 1);
    assign load_addr = AW'(32'(item.channel) * 32'(LEVELS) + 32'(item.level));
    assign map_addr  = AW'(32'(item.channel) * 32'(LEVELS) + map_level);

    always_comb
    begin
        if (is_alpha)
        begin
            sel_next = SEL_PASS;
        end
        else if (!ch_in_range)
        begin
            sel_next = SEL_ZERO;
        end
        else
        begin
            sel_next = SEL_TABLE;
        end
    end

    assign div_req.start = load_accept;
    assign div_req.sum   = sum_next;
    assign div_req.total = total_pixels_reg;

    assign tbl_we = div_rsp.done && wr_valid_reg;

    hel_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hel_table #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (hel_pkg::LEVEL_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (wr_addr_reg),
        .wr_data (div_rsp.quotient),
        .rd_en   (map_accept),
        .rd_addr (map_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= hel_pkg::NUM_CH_RESET;
            total_pixels_reg <= hel_pkg::TOTAL_RESET;
            running_sum_reg  <= '0;
            busy_reg         <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hel_pkg::CFG_NUM_CHANNELS:
                    begin
                        num_channels_reg <= cfg_data[hel_pkg::NUM_CH_W-1:0];
                    end
                    hel_pkg::CFG_TOTAL_PIXELS:
                    begin
                        total_pixels_reg <= cfg_data[hel_pkg::COUNT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (load_accept)
            begin
                running_sum_reg <= sum_next;
                busy_reg        <= 1'b1;
            end
            else if (div_rsp.done)
            begin
                busy_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                s1_valid_reg  <= map_accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            wr_valid_reg <= ch_in_range && lv_in_range;
            wr_addr_reg  <= load_addr;
        end
        if (advance)
        begin
            case (s1_sel_reg)
                SEL_PASS:  out_level_reg <= s1_level_reg;
                SEL_ZERO:  out_level_reg <= '0;
                default:   out_level_reg <= rd_data;
            endcase
        end
        if (map_accept)
        begin
            s1_sel_reg   <= sel_next;
            s1_level_reg <= item.level;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.mapped_level = out_level_reg;

    a_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> busy_reg)
        else $error("Table write outside a load.");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> busy_reg)
        else $error("Divider finished with no load pending.");

    a_load_starts_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_accept |=> busy_reg && !item.ready)
        else $error("Load item did not lock the input.");

endmodule
